>>> rtl/smac_pkg.sv
// ---------------------------------------------------------------------------
// smac_pkg: shared definitions for the scaled Manhattan anomaly check
// Field widths, fixed-point formats, channel codes and register indexes.
// ---------------------------------------------------------------------------
package smac_pkg;

  // Sizing of the sample and of the timing fields.
  localparam int MAX_ELEMENTS  = 64;
  localparam int INTERVAL_BITS = 16;

  // Field widths.
  localparam int FUNC_W    = 2;
  localparam int FIELD_W   = 16;
  localparam int FRAC_W    = 16;
  localparam int TERM_W    = 24;
  localparam int SUM_W     = 30;
  localparam int NUM_CH    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int COUNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int STEP_W    = $clog2(TERM_W);

  // Bits of a dividend that sit above the quotient window.
  localparam int T_HEAD_W = FIELD_W + FRAC_W - TERM_W;
  localparam int A_HEAD_W = SUM_W - TERM_W;

  typedef logic [FUNC_W-1:0]    func_t;
  typedef logic [FIELD_W-1:0]   field_t;
  typedef logic [TERM_W-1:0]    term_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Interval bits that take part in the distance.
  localparam field_t IV_MASK = (INTERVAL_BITS >= FIELD_W) ? '1 :
                               FIELD_W'((64'd1 << INTERVAL_BITS) - 64'd1);

  localparam term_t  TERM_MAX    = '1;
  localparam sum_t   SUM_MAX     = '1;
  localparam count_t COUNT_LIMIT = COUNT_W'(MAX_ELEMENTS);

  // Channel codes carried by func.
  localparam func_t CH_DD   = 2'd0;
  localparam func_t CH_UD   = 2'd1;
  localparam func_t CH_DU   = 2'd2;
  localparam func_t CH_NONE = 2'd3;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_DD_THR = 2'd0;
  localparam cfg_idx_t CFG_UD_THR = 2'd1;
  localparam cfg_idx_t CFG_DU_THR = 2'd2;

endpackage

>>> rtl/smac_ifs.sv
// ---------------------------------------------------------------------------
// smac_ifs: handshake channels of the scaled Manhattan anomaly check
// Timing element input, result output and threshold write channel.
// ---------------------------------------------------------------------------

// One timing element per beat.
interface smac_in_if;
  logic                  valid;
  logic                  ready;
  smac_pkg::func_t       func;
  smac_pkg::field_t      interval;
  smac_pkg::field_t      mean;
  smac_pkg::field_t      spread;
  logic                  last;

  modport source (output valid, func, interval, mean, spread, last, input ready);
  modport sink   (input valid, func, interval, mean, spread, last, output ready);
endinterface

// One sample verdict per beat.
interface smac_out_if;
  logic                  valid;
  logic                  ready;
  smac_pkg::term_t       dd_distance;
  smac_pkg::term_t       ud_distance;
  smac_pkg::term_t       du_distance;
  logic                  dd_ok;
  logic                  ud_ok;
  logic                  du_ok;
  logic                  all_ok;

  modport source (output valid, dd_distance, ud_distance, du_distance,
                  dd_ok, ud_ok, du_ok, all_ok, input ready);
  modport sink   (input valid, dd_distance, ud_distance, du_distance,
                  dd_ok, ud_ok, du_ok, all_ok, output ready);
endinterface

// One threshold register write per beat.
interface smac_cfg_if;
  logic                  valid;
  logic                  ready;
  smac_pkg::cfg_idx_t    index;
  smac_pkg::term_t       data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/scaled_manhattan_anomaly_check_unit.sv
// ---------------------------------------------------------------------------
// scaled_manhattan_anomaly_check_unit: keystroke timing anomaly check
// Accumulates |interval - mean| / spread per channel and, on the last
// element of a sample, reports the channel averages against thresholds.
// ---------------------------------------------------------------------------
//
//  Channel   Dir  Beat carries
//  in_ch     in   func, interval, mean, spread, last
//  out_ch    out  dd/ud/du_distance, dd/ud/du_ok, all_ok
//  cfg_ch    in   index, data (threshold write, always ready)
//
// An element keeps in_ch not ready from its beat through prep, the term
// division (skipped if the term saturates) and the accumulate step, or just
// through prep if it is dropped; a last element then runs the average check,
// division and store per channel and a publish step. The one shared restoring
// divider retires a quotient bit per cycle. Reset clears the sums, counts and
// thresholds at once. A stalled out_ch holds its beat; the next sample is
// accumulated meanwhile and only waits at publish time.
// ---------------------------------------------------------------------------
module scaled_manhattan_anomaly_check_unit (
  input  logic              clk,
  input  logic              rst_n,
  smac_in_if.sink           in_ch,
  smac_out_if.source        out_ch,
  smac_cfg_if.sink          cfg_ch
);

  // Sequencer codes.
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PREP   = 3'd1;
  localparam logic [2:0] S_TDIV   = 3'd2;
  localparam logic [2:0] S_ACC    = 3'd3;
  localparam logic [2:0] S_ACHK   = 3'd4;
  localparam logic [2:0] S_ADIV   = 3'd5;
  localparam logic [2:0] S_ASTORE = 3'd6;
  localparam logic [2:0] S_PUB    = 3'd7;

  logic [2:0]                           state_r, state_nxt;
  smac_pkg::func_t                      chan_r;
  logic                                 last_r;
  smac_pkg::field_t                     diff_r;
  smac_pkg::field_t                     dvs_r;
  smac_pkg::field_t                     rem_r;
  smac_pkg::term_t                      sh_r;
  logic [smac_pkg::STEP_W-1:0]          step_r;
  smac_pkg::sum_t                       sum_r      [smac_pkg::NUM_CH];
  smac_pkg::count_t                     cnt_r      [smac_pkg::NUM_CH];
  smac_pkg::term_t                      thr_r      [smac_pkg::NUM_CH];
  smac_pkg::term_t                      dist_r     [smac_pkg::NUM_CH];
  logic [smac_pkg::NUM_CH-1:0]          ok_r;
  smac_pkg::term_t                      out_dist_r [smac_pkg::NUM_CH];
  logic [smac_pkg::NUM_CH-1:0]          out_ok_r;
  logic                                 out_all_r;
  logic                                 out_valid_r, out_valid_nxt;

  logic                                 in_fire;
  logic                                 pub_fire;
  smac_pkg::field_t                     iv_m, mn_m, sd_m, diff_in;
  smac_pkg::sum_t                       sum_sel;
  smac_pkg::count_t                     cnt_sel;
  smac_pkg::term_t                      thr_sel;
  logic                                 chan_ok;
  logic                                 take;
  logic [smac_pkg::FIELD_W+smac_pkg::FRAC_W-1:0] num_term;
  smac_pkg::field_t                     t_head, a_head;
  logic                                 term_sat, avg_sat, cnt_zero;
  logic [smac_pkg::FIELD_W:0]           trial;
  logic                                 q_bit;
  smac_pkg::field_t                     rem_step;
  smac_pkg::term_t                      sh_step;
  logic                                 div_done;
  logic [smac_pkg::SUM_W:0]             sum_wide;
  smac_pkg::sum_t                       sum_acc;

  // Handshakes.
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_fire      = in_ch.valid && (state_r == S_IDLE);
  assign pub_fire     = (state_r == S_PUB) && (!out_valid_r || out_ch.ready);

  // A result beat is raised on publish and held until it is taken.
  assign out_valid_nxt = pub_fire ? 1'b1 : (out_valid_r && !out_ch.ready);

  // Absolute difference of the masked interval and mean.
  always_comb begin
    iv_m    = in_ch.interval & smac_pkg::IV_MASK;
    mn_m    = in_ch.mean & smac_pkg::IV_MASK;
    sd_m    = in_ch.spread & smac_pkg::IV_MASK;
    diff_in = (iv_m >= mn_m) ? (iv_m - mn_m) : (mn_m - iv_m);
  end

  // Per-channel state seen at the current channel pointer.
  always_comb begin
    sum_sel = '0;
    cnt_sel = '0;
    thr_sel = '0;
    chan_ok = 1'b0;
    for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
      if (chan_r == smac_pkg::func_t'(c)) begin
        sum_sel = sum_r[c];
        cnt_sel = cnt_r[c];
        thr_sel = thr_r[c];
        chan_ok = 1'b1;
      end
    end
  end

  // Division setup and saturation checks. A quotient overflows the term
  // window exactly when the dividend head is not below the divisor, which
  // also covers a zero spread.
  always_comb begin
    take     = chan_ok && (cnt_sel < smac_pkg::COUNT_LIMIT);
    num_term = {diff_r, {smac_pkg::FRAC_W{1'b0}}};
    t_head   = smac_pkg::FIELD_W'(num_term[smac_pkg::FIELD_W+smac_pkg::FRAC_W-1:
                                           smac_pkg::TERM_W]);
    a_head   = smac_pkg::FIELD_W'(sum_sel[smac_pkg::SUM_W-1:smac_pkg::TERM_W]);
    term_sat = (t_head >= dvs_r);
    cnt_zero = (cnt_sel == '0);
    avg_sat  = (a_head >= smac_pkg::FIELD_W'(cnt_sel));
  end

  // One restoring division step: shift in a dividend bit, try the subtract.
  always_comb begin
    trial    = {rem_r, sh_r[smac_pkg::TERM_W-1]};
    q_bit    = (trial >= {1'b0, dvs_r});
    rem_step = q_bit ? smac_pkg::FIELD_W'(trial - {1'b0, dvs_r})
                     : trial[smac_pkg::FIELD_W-1:0];
    sh_step  = {sh_r[smac_pkg::TERM_W-2:0], q_bit};
    div_done = (step_r == smac_pkg::STEP_W'(smac_pkg::TERM_W - 1));
  end

  // Saturating accumulate of the finished term.
  always_comb begin
    sum_wide = {1'b0, sum_sel} + (smac_pkg::SUM_W + 1)'(sh_r);
    sum_acc  = sum_wide[smac_pkg::SUM_W] ? smac_pkg::SUM_MAX
                                         : sum_wide[smac_pkg::SUM_W-1:0];
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = S_PREP;
      end
      S_PREP: begin
        if (!take)         state_nxt = last_r ? S_ACHK : S_IDLE;
        else if (term_sat) state_nxt = S_ACC;
        else               state_nxt = S_TDIV;
      end
      S_TDIV: begin
        if (div_done) state_nxt = S_ACC;
      end
      S_ACC: begin
        state_nxt = last_r ? S_ACHK : S_IDLE;
      end
      S_ACHK: begin
        state_nxt = (cnt_zero || avg_sat) ? S_ASTORE : S_ADIV;
      end
      S_ADIV: begin
        if (div_done) state_nxt = S_ASTORE;
      end
      S_ASTORE: begin
        state_nxt = (chan_r == smac_pkg::CH_DU) ? S_PUB : S_ACHK;
      end
      S_PUB: begin
        if (pub_fire) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
        sum_r[c] <= '0;
        cnt_r[c] <= '0;
        thr_r[c] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;

      // Threshold writes; an index past the list is dropped.
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          smac_pkg::CFG_DD_THR: thr_r[0] <= cfg_ch.data;
          smac_pkg::CFG_UD_THR: thr_r[1] <= cfg_ch.data;
          smac_pkg::CFG_DU_THR: thr_r[2] <= cfg_ch.data;
          default: ;
        endcase
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            chan_r <= in_ch.func;
            last_r <= in_ch.last;
            diff_r <= diff_in;
            dvs_r  <= sd_m;
          end
        end
        S_PREP: begin
          rem_r  <= t_head;
          sh_r   <= term_sat ? smac_pkg::TERM_MAX : num_term[smac_pkg::TERM_W-1:0];
          step_r <= '0;
          if (!take && last_r) chan_r <= smac_pkg::CH_DD;
        end
        S_TDIV, S_ADIV: begin
          rem_r  <= rem_step;
          sh_r   <= sh_step;
          step_r <= step_r + 1'b1;
        end
        S_ACC: begin
          for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
            if (chan_r == smac_pkg::func_t'(c)) begin
              sum_r[c] <= sum_acc;
              cnt_r[c] <= cnt_r[c] + 1'b1;
            end
          end
          if (last_r) chan_r <= smac_pkg::CH_DD;
        end
        S_ACHK: begin
          rem_r  <= a_head;
          dvs_r  <= smac_pkg::FIELD_W'(cnt_sel);
          step_r <= '0;
          if (cnt_zero)     sh_r <= '0;
          else if (avg_sat) sh_r <= smac_pkg::TERM_MAX;
          else              sh_r <= sum_sel[smac_pkg::TERM_W-1:0];
        end
        S_ASTORE: begin
          for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
            if (chan_r == smac_pkg::func_t'(c)) begin
              dist_r[c] <= sh_r;
              ok_r[c]   <= !cnt_zero && (sh_r <= thr_sel);
            end
          end
          chan_r <= chan_r + 1'b1;
        end
        S_PUB: begin
          if (pub_fire) begin
            out_all_r   <= &ok_r;
            out_ok_r    <= ok_r;
            for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
              out_dist_r[c] <= dist_r[c];
              sum_r[c]      <= '0;
              cnt_r[c]      <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Result beat.
  assign out_ch.valid       = out_valid_r;
  assign out_ch.dd_distance = out_dist_r[0];
  assign out_ch.ud_distance = out_dist_r[1];
  assign out_ch.du_distance = out_dist_r[2];
  assign out_ch.dd_ok       = out_ok_r[0];
  assign out_ch.ud_ok       = out_ok_r[1];
  assign out_ch.du_ok       = out_ok_r[2];
  assign out_ch.all_ok      = out_all_r;

  // No channel ever counts past the sample limit.
  a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[0] <= smac_pkg::COUNT_LIMIT) && (cnt_r[1] <= smac_pkg::COUNT_LIMIT) &&
    (cnt_r[2] <= smac_pkg::COUNT_LIMIT))
    else $error("channel count above sample limit");

  // The partial remainder stays below the divisor throughout a division.
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TDIV || state_r == S_ADIV) |-> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  // Publishing a result leaves every channel empty.
  a_clear_after_pub: assert property (@(posedge clk) disable iff (!rst_n)
    pub_fire |=> (cnt_r[0] == '0 && cnt_r[1] == '0 && cnt_r[2] == '0 &&
                  sum_r[0] == '0 && sum_r[1] == '0 && sum_r[2] == '0))
    else $error("channel state not cleared after publish");

  // A result beat only appears out of the publish step.
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_PUB))
    else $error("result valid raised outside publish");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for scaled_manhattan_anomaly_check_unit
// Drives timing elements and result back-pressure with random gaps plus
// threshold writes, predicts every sample verdict and checks each result beat
// field by field against the oldest predicted verdict.
// ---------------------------------------------------------------------------

// One timing element as it travels on the input channel.
typedef struct packed {
  smac_pkg::func_t  func;
  smac_pkg::field_t interval;
  smac_pkg::field_t mean;
  smac_pkg::field_t spread;
  logic             last;
} element_t;

// One sample verdict; index 0 is down-down, 1 up-down, 2 down-up.
typedef struct packed {
  smac_pkg::term_t [smac_pkg::NUM_CH-1:0] distance;
  logic            [smac_pkg::NUM_CH-1:0] ok;
  logic                                   all_ok;
} verdict_t;

// Tracks per-channel sums and counts and queues the verdict of every sample.
class verdict_scoreboard;
  smac_pkg::term_t  threshold [smac_pkg::NUM_CH];
  smac_pkg::sum_t   ch_sum    [smac_pkg::NUM_CH];
  smac_pkg::count_t ch_count  [smac_pkg::NUM_CH];
  verdict_t         pending   [$];
  string            ch_name   [smac_pkg::NUM_CH];
  int               errors;

  function new();
    ch_name = '{"dd", "ud", "du"};
    errors  = 0;
    for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
      threshold[c] = '0;
      ch_sum[c]    = '0;
      ch_count[c]  = '0;
    end
  endfunction

  function int outstanding();
    return pending.size();
  endfunction

  // Register writes with an unused index leave all thresholds alone.
  function void write_register(smac_pkg::cfg_idx_t idx, smac_pkg::term_t data);
    case (idx)
      smac_pkg::CFG_DD_THR: threshold[0] = data;
      smac_pkg::CFG_UD_THR: threshold[1] = data;
      smac_pkg::CFG_DU_THR: threshold[2] = data;
      default: ;
    endcase
  endfunction

  // |interval - mean| / spread in UQ8.16, truncated and saturated.
  static function smac_pkg::term_t scaled_term(smac_pkg::field_t iv, smac_pkg::field_t mn,
                                               smac_pkg::field_t sd);
    logic [63:0] delta;
    logic [63:0] quo;
    iv = iv & smac_pkg::IV_MASK;
    mn = mn & smac_pkg::IV_MASK;
    sd = sd & smac_pkg::IV_MASK;
    delta = (iv >= mn) ? 64'(iv - mn) : 64'(mn - iv);
    if (sd == '0) return smac_pkg::TERM_MAX;
    quo = (delta << smac_pkg::FRAC_W) / 64'(sd);
    return (quo > 64'(smac_pkg::TERM_MAX)) ? smac_pkg::TERM_MAX
                                           : quo[smac_pkg::TERM_W-1:0];
  endfunction

  // Accumulates one accepted element; a last element closes the sample.
  function void note_element(element_t e);
    verdict_t       v;
    logic [31:0]    acc;
    smac_pkg::sum_t quo;
    int             ch;
    ch = int'(e.func);
    if (e.func != smac_pkg::CH_NONE && ch_count[ch] < smac_pkg::COUNT_LIMIT) begin
      acc = ch_sum[ch] + scaled_term(e.interval, e.mean, e.spread);
      ch_sum[ch] = (acc > 32'(smac_pkg::SUM_MAX)) ? smac_pkg::SUM_MAX
                                                  : acc[smac_pkg::SUM_W-1:0];
      ch_count[ch]++;
    end
    if (!e.last) return;

    // An empty channel reports zero distance and never passes.
    v.all_ok = 1'b1;
    for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
      v.distance[c] = '0;
      v.ok[c]       = 1'b0;
      if (ch_count[c] != '0) begin
        quo = ch_sum[c] / smac_pkg::SUM_W'(ch_count[c]);
        v.distance[c] = (quo > smac_pkg::SUM_W'(smac_pkg::TERM_MAX)) ?
                        smac_pkg::TERM_MAX : quo[smac_pkg::TERM_W-1:0];
        v.ok[c]       = (v.distance[c] <= threshold[c]);
      end
      v.all_ok &= v.ok[c];
      ch_sum[c]   = '0;
      ch_count[c] = '0;
    end
    pending.push_back(v);
  endfunction

  function void check_verdict(verdict_t got);
    verdict_t want;
    if (pending.size() == 0) begin
      $error("result beat arrived with no verdict pending");
      errors++;
      return;
    end
    want = pending.pop_front();
    for (int c = 0; c < smac_pkg::NUM_CH; c++) begin
      if (got.distance[c] !== want.distance[c]) begin
        $error("%s_distance: expected %06h, got %06h", ch_name[c], want.distance[c],
               got.distance[c]);
        errors++;
      end
      if (got.ok[c] !== want.ok[c]) begin
        $error("%s_ok: expected %0b, got %0b", ch_name[c], want.ok[c], got.ok[c]);
        errors++;
      end
    end
    if (got.all_ok !== want.all_ok) begin
      $error("all_ok: expected %0b, got %0b", want.all_ok, got.all_ok);
      errors++;
    end
  endfunction
endclass

module tb;

  // Index with no register behind it.
  localparam smac_pkg::cfg_idx_t CFG_SPARE = 2'd3;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 120;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int PHASES        = 6;

  logic clk;
  logic rst_n;

  smac_in_if  in_ch();
  smac_out_if out_ch();
  smac_cfg_if cfg_ch();

  scaled_manhattan_anomaly_check_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  verdict_scoreboard sb = new();

  int src_run     = 0;
  int sink_run    = 0;
  int idle_cycles = 0;
  int sent        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap before a beat: usually drawn at random, with occasional runs of none.
  function automatic int draw_gap(inout int run);
    if (run > 0) begin
      run--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      run = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic element_t make_element(smac_pkg::func_t f, smac_pkg::field_t iv,
                                            smac_pkg::field_t mn, smac_pkg::field_t sd,
                                            logic lst);
    element_t e;
    e.func     = f;
    e.interval = iv;
    e.mean     = mn;
    e.spread   = sd;
    e.last     = lst;
    return e;
  endfunction

  // Mostly plausible timings near the mean, plus raw and degenerate ones.
  function automatic element_t random_element(smac_pkg::func_t f, logic lst);
    element_t e;
    int       m;
    int       s;
    int       d;
    int       v;
    e = make_element(f, smac_pkg::field_t'($urandom), smac_pkg::field_t'($urandom),
                     smac_pkg::field_t'($urandom), lst);
    case ($urandom_range(0, 19)) inside
      [0:2]: ;
      3: e.spread = '0;
      4: e.interval = e.mean;
      default: begin
        m = $urandom_range(0, 65535);
        s = $urandom_range(1, 3000);
        d = $urandom_range(0, 4 * s);
        v = ($urandom_range(0, 1) == 1) ? m + d : m - d;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        e.interval = smac_pkg::field_t'(v);
        e.mean     = smac_pkg::field_t'(m);
        e.spread   = smac_pkg::field_t'(s);
      end
    endcase
    return e;
  endfunction

  // Holds valid high across back-to-back beats; only a gap lowers it.
  task automatic send_element(element_t e);
    int gap;
    gap = draw_gap(src_run);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.func     <= e.func;
    in_ch.interval <= e.interval;
    in_ch.mean     <= e.mean;
    in_ch.spread   <= e.spread;
    in_ch.last     <= e.last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_element(e);
    sent++;
  endtask

  // One sample; a full one packs a single channel up to or past its element limit.
  task automatic send_sample(bit force_full);
    int              n;
    bit              full;
    smac_pkg::func_t solo;
    smac_pkg::func_t f;
    full = force_full || ($urandom_range(0, 24) == 0);
    n    = full ? $urandom_range(60, 75) : $urandom_range(1, 16);
    solo = smac_pkg::func_t'($urandom_range(0, 2));
    for (int i = 0; i < n; i++) begin
      if (full) f = solo;
      else if ($urandom_range(0, 19) == 0) f = smac_pkg::CH_NONE;
      else f = smac_pkg::func_t'($urandom_range(0, 2));
      send_element(random_element(f, i == n - 1));
    end
  endtask

  // All three thresholds plus a write to the unused index.
  task automatic write_thresholds(smac_pkg::term_t dd, smac_pkg::term_t ud,
                                  smac_pkg::term_t du);
    smac_pkg::cfg_idx_t order [4];
    smac_pkg::term_t    value [4];
    order = '{smac_pkg::CFG_DD_THR, smac_pkg::CFG_UD_THR, smac_pkg::CFG_DU_THR, CFG_SPARE};
    value = '{dd, ud, du, smac_pkg::term_t'($urandom)};
    for (int k = 0; k < 4; k++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= order[k];
      cfg_ch.data  <= value[k];
      @(posedge clk);
      while (!cfg_ch.ready) @(posedge clk);
      sb.write_register(order[k], value[k]);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Stop sending and let every pending verdict come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int phase_start;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.func     <= smac_pkg::CH_DD;
    in_ch.interval <= '0;
    in_ch.mean     <= '0;
    in_ch.spread   <= '0;
    in_ch.last     <= 1'b0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= smac_pkg::CFG_DD_THR;
    cfg_ch.data    <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Thresholds at reset value: overflowed, zero-spread and ignored elements.
    send_element(make_element(smac_pkg::CH_DD, 16'hFFFF, 16'h0000, 16'h0001, 1'b0));
    send_element(make_element(smac_pkg::CH_UD, 16'h0000, 16'hFFFF, 16'hFFFF, 1'b0));
    send_element(make_element(smac_pkg::CH_DU, 16'd1234, 16'd1234, 16'h0000, 1'b0));
    send_element(make_element(smac_pkg::CH_NONE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0));
    send_element(make_element(smac_pkg::CH_DD, 16'h0000, 16'h0000, 16'hFFFF, 1'b1));
    // A sample with nothing in it, and one with a single channel.
    send_element(make_element(smac_pkg::CH_NONE, 16'h0000, 16'h0000, 16'h0000, 1'b1));
    send_element(make_element(smac_pkg::CH_UD, 16'd300, 16'd100, 16'd50, 1'b1));
    // Zero distance everywhere passes even a zero threshold.
    send_element(make_element(smac_pkg::CH_DD, 16'd7, 16'd7, 16'd1, 1'b0));
    send_element(make_element(smac_pkg::CH_UD, 16'd7, 16'd7, 16'd9, 1'b0));
    send_element(make_element(smac_pkg::CH_DU, 16'd0, 16'd0, 16'd1, 1'b1));
    // Sample closed by an element on the unused channel code.
    send_element(make_element(smac_pkg::CH_DU, 16'd9, 16'd5, 16'd3, 1'b0));
    send_element(make_element(smac_pkg::CH_DD, 16'hFFFF, 16'h0001, 16'hFFFF, 1'b0));
    send_element(make_element(smac_pkg::CH_NONE, 16'd12345, 16'd54321, 16'h0000, 1'b1));
    drain();

    // Averages of exactly 1.0 against limits at and just below 1.0.
    write_thresholds(24'h010000, 24'h00FFFF, 24'h010000);
    send_element(make_element(smac_pkg::CH_DD, 16'd10, 16'd9, 16'd1, 1'b0));
    send_element(make_element(smac_pkg::CH_UD, 16'd10, 16'd9, 16'd1, 1'b0));
    send_element(make_element(smac_pkg::CH_DU, 16'd9, 16'd10, 16'd1, 1'b1));
    drain();

    // Random samples, with the thresholds changed between phases.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: write_thresholds('1, '1, '1);
        1: write_thresholds('0, '0, '0);
        2: write_thresholds(smac_pkg::term_t'($urandom), smac_pkg::term_t'($urandom),
                            smac_pkg::term_t'($urandom));
        4: write_thresholds('0, '1, smac_pkg::term_t'($urandom_range(0, 24'h40000)));
        default: write_thresholds(smac_pkg::term_t'($urandom_range(0, 24'h40000)),
                                  smac_pkg::term_t'($urandom_range(0, 24'h40000)),
                                  smac_pkg::term_t'($urandom_range(0, 24'h40000)));
      endcase
      phase_start = sent;
      send_sample(p == 0);
      while (sent - phase_start < RANDOM_ITEMS / PHASES) send_sample(1'b0);
      drain();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("[scaled_manhattan_anomaly_check_unit] OK");
    end else begin
      $display("[scaled_manhattan_anomaly_check_unit] ERROR");
    end
    $finish;
  end

  // Result side: random back-pressure, each accepted beat is checked.
  initial begin
    verdict_t got;
    int       gap;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap(sink_run);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rst_n === 1'b1 && out_ch.valid === 1'b1)) @(posedge clk);
      got.distance[0] = out_ch.dd_distance;
      got.distance[1] = out_ch.ud_distance;
      got.distance[2] = out_ch.du_distance;
      got.ok[0]       = out_ch.dd_ok;
      got.ok[1]       = out_ch.ud_ok;
      got.ok[2]       = out_ch.du_ok;
      got.all_ok      = out_ch.all_ok;
      sb.check_verdict(got);
    end
  end

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("[scaled_manhattan_anomaly_check_unit] ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
